>>> src/hrf_pkg.sv
// Shared types and constants for the HID report framer.
package hrf_pkg;

   // Report geometry.
   localparam int REPORT_BYTES = 64;
   localparam int FILL_W = $clog2(REPORT_BYTES);
   localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(REPORT_BYTES - 1);

   // Header lengths in bytes, and the header byte positions of the sequence or command byte and the length bytes.
   localparam logic [2:0] HDR_NONE = 3'd0;
   localparam logic [2:0] HDR_CONT_LEN = 3'd5;
   localparam logic [2:0] HDR_FIRST_LEN = 3'd7;
   localparam logic [2:0] HDR_POS_CMD = 3'd4;
   localparam logic [2:0] HDR_POS_LEN_HI = 3'd5;
   localparam logic [2:0] HDR_POS_LEN_LO = 3'd6;

   // Action codes of an input item.
   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_DATA = 2'd1;
   localparam logic [1:0] ACT_FLUSH = 2'd2;

   // Input item.
   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] channel_id;
      logic [7:0]  command;
      logic [15:0] byte_count;
      logic [7:0]  data_byte;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [7:0] report_byte;
      logic       last_of_report;
      logic       last_of_step;
   } rsp_type;

   // Held input item toward the sequencer.
   typedef struct packed {
      logic    valid;
      req_type item;
   } held_type;

   // Byte offered by the sequencer to the output register.
   typedef struct packed {
      logic    valid;
      rsp_type item;
   } emit_type;

endpackage

>>> src/hrf_item_reg.sv
// Input register that holds one accepted item until the sequencer retires it.
module hrf_item_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hrf_pkg::req_type  req_item,
   input  logic              done,
   output hrf_pkg::held_type held
);

   logic             valid_ff;
   logic             valid_in;
   hrf_pkg::req_type item_ff;

   // A new item may enter when the register is empty or its item retires now.
   assign req_ready = !valid_ff || done;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (done) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign held.valid = valid_ff;
   assign held.item = item_ff;

endmodule

>>> src/hrf_sequencer.sv
// Message state and byte selection: header, data and padding bytes one per cycle while the output register is free.
module hrf_sequencer (
   input  logic              clock,
   input  logic              reset,
   input  hrf_pkg::held_type held,
   input  logic              out_free,
   output logic              done,
   output hrf_pkg::emit_type emit
);

   logic [31:0]               channel_ff;
   logic [7:0]                command_ff;
   logic [15:0]               length_ff;
   logic [hrf_pkg::FILL_W-1:0] fill_pos_ff;
   logic                      any_written_ff;
   logic [7:0]                seq_ff;
   logic [2:0]                phase_ff;
   logic [2:0]                hdr_len_ff;

   logic [2:0] hdr_calc;
   logic [2:0] hdr_len_now;
   logic       in_hdr;
   logic [7:0] hdr_byte;
   logic       emit_want;
   logic       last_step;
   logic [7:0] out_byte;
   logic       go;
   logic       last_rep;

   // Header needed by this item, decided on its first byte and held afterward.
   always_comb begin
      hdr_calc = hrf_pkg::HDR_NONE;
      case (held.item.action)
         hrf_pkg::ACT_DATA: begin
            if (fill_pos_ff == '0) begin
               hdr_calc = any_written_ff ? hrf_pkg::HDR_CONT_LEN : hrf_pkg::HDR_FIRST_LEN;
            end
         end
         hrf_pkg::ACT_FLUSH: begin
            if (fill_pos_ff == '0 && !any_written_ff) begin
               hdr_calc = hrf_pkg::HDR_FIRST_LEN;
            end
         end
         default: hdr_calc = hrf_pkg::HDR_NONE;
      endcase
   end

   assign hdr_len_now = (phase_ff == 3'd0) ? hdr_calc : hdr_len_ff;
   assign in_hdr = phase_ff < hdr_len_now;

   // Header byte at the current position: channel id low byte first.
   always_comb begin
      unique case (phase_ff)
         3'd0: hdr_byte = channel_ff[7:0];
         3'd1: hdr_byte = channel_ff[15:8];
         3'd2: hdr_byte = channel_ff[23:16];
         3'd3: hdr_byte = channel_ff[31:24];
         hrf_pkg::HDR_POS_CMD: begin
            hdr_byte = (hdr_len_now == hrf_pkg::HDR_FIRST_LEN) ? command_ff : seq_ff;
         end
         hrf_pkg::HDR_POS_LEN_HI: hdr_byte = length_ff[15:8];
         hrf_pkg::HDR_POS_LEN_LO: hdr_byte = length_ff[7:0];
         default: hdr_byte = 8'd0;
      endcase
   end

   // Decide what this cycle emits for the held item.
   always_comb begin
      emit_want = 1'b0;
      last_step = 1'b0;
      out_byte = 8'd0;
      if (held.valid) begin
         case (held.item.action)
            hrf_pkg::ACT_DATA: begin
               emit_want = 1'b1;
               last_step = !in_hdr;
               out_byte = in_hdr ? hdr_byte : held.item.data_byte;
            end
            hrf_pkg::ACT_FLUSH: begin
               if (in_hdr) begin
                  emit_want = 1'b1;
                  out_byte = hdr_byte;
               end else if (fill_pos_ff != '0) begin
                  emit_want = 1'b1;
                  last_step = (fill_pos_ff == hrf_pkg::FILL_LAST);
               end
            end
            default: emit_want = 1'b0;
         endcase
      end
   end

   assign last_rep = (fill_pos_ff == hrf_pkg::FILL_LAST);
   assign go = emit_want && out_free;
   assign done = held.valid && (emit_want ? (go && last_step) : 1'b1);

   assign emit.valid = emit_want;
   assign emit.item.report_byte = out_byte;
   assign emit.item.last_of_report = last_rep;
   assign emit.item.last_of_step = last_step;

   // Message state update.
   always_ff @(posedge clock) begin
      if (reset) begin
         channel_ff <= '0;
         command_ff <= '0;
         length_ff <= '0;
         fill_pos_ff <= '0;
         any_written_ff <= 1'b0;
         seq_ff <= '0;
         phase_ff <= '0;
         hdr_len_ff <= '0;
      end else begin
         if (go) begin
            fill_pos_ff <= last_rep ? '0 : fill_pos_ff + 1'b1;
            phase_ff <= last_step ? 3'd0 : phase_ff + 3'd1;
            hdr_len_ff <= hdr_len_now;
            if (in_hdr && phase_ff == hrf_pkg::HDR_POS_CMD &&
                hdr_len_now == hrf_pkg::HDR_CONT_LEN) begin
               seq_ff <= seq_ff + 8'd1;
            end
         end
         if (done) begin
            phase_ff <= 3'd0;
            case (held.item.action)
               hrf_pkg::ACT_START: begin
                  channel_ff <= held.item.channel_id;
                  command_ff <= held.item.command;
                  length_ff <= held.item.byte_count;
                  fill_pos_ff <= '0;
                  any_written_ff <= 1'b0;
                  seq_ff <= '0;
               end
               hrf_pkg::ACT_DATA: any_written_ff <= 1'b1;
               hrf_pkg::ACT_FLUSH: begin
                  any_written_ff <= 1'b1;
                  fill_pos_ff <= '0;
               end
               default: any_written_ff <= any_written_ff;
            endcase
         end
      end
   end

endmodule

>>> src/hrf_out_reg.sv
// Output register for result items.
module hrf_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  hrf_pkg::emit_type emit,
   output logic              out_free,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hrf_pkg::rsp_type  rsp_item
);

   logic             valid_ff;
   hrf_pkg::rsp_type item_ff;

   // The register takes a new byte when empty or when its byte leaves now.
   assign out_free = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_free) begin
         valid_ff <= emit.valid;
      end
      if (out_free && emit.valid) begin
         item_ff <= emit.item;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item = item_ff;

endmodule

>>> src/hid_report_framer.sv
// Top level of the HID report framer.
//
// Usage: items arrive on the req_ channel (valid/ready). A start item latches the
// channel id, command and byte count; data items each carry one payload byte; a
// flush closes the open report with zero padding, or sends a header-only report
// when nothing was sent yet. The rsp_ channel (valid/ready) carries the report
// stream one byte per item, with last_of_report on byte 64 of each report and
// last_of_step on the last byte caused by an input item.
// Order: an accepted item is held in the input register, and its bytes pass
// from the sequencer into the output register, which drives rsp_valid. The
// sequencer emits one byte per cycle while the output register is free: a data
// byte inside an open report emits just that byte, a data byte that opens a
// report emits a 5- or 7-byte header first, a flush emits its padding or
// header bytes, and start items and flushes with nothing to send emit none.
// Reset clears the message state to zero and empties both registers. When the
// receiver holds rsp_ready low, the output register keeps its byte, the
// sequencer waits, and req_ready drops while the held item has bytes to send.
module hid_report_framer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hrf_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hrf_pkg::rsp_type rsp_item
);

   hrf_pkg::held_type held;
   hrf_pkg::emit_type emit;
   logic              done;
   logic              out_free;

   // Input register.
   hrf_item_reg u_item_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .done      (done),
      .held      (held)
   );

   // Header, data and padding sequencing.
   hrf_sequencer u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .held     (held),
      .out_free (out_free),
      .done     (done),
      .emit     (emit)
   );

   // Output register.
   hrf_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .emit      (emit),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

>>> bench/hid_report_framer_tb.sv
// Self-checking testbench for the HID report framer: directed and random items, checked byte by byte.
module hid_report_framer_tb;

   localparam int CLK_HALF = 6;
   localparam int RESET_CYCLES = 3;
   localparam int MAX_STEP_BYTES = 64;
   localparam int LONG_HOLD = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int TIMEOUT_CYCLES = 1_000_000;
   localparam int RANDOM_ITEMS = 150;
   localparam int WRAP_REPORTS = 259;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // Receiver stall patterns.
   typedef enum int {RX_ALWAYS, RX_COIN, RX_THIRD, RX_BURSTY} rx_mode_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   hrf_pkg::req_type req_item;
   logic             rsp_valid;
   logic             rsp_ready;
   hrf_pkg::rsp_type rsp_item;

   // Predicted report stream, oldest byte first.
   hrf_pkg::rsp_type report_stream_q[$];
   int               fail_count = 0;
   int               items_sent = 0;

   // Shadow of the framer's message state.
   logic [31:0] msg_channel;
   logic [7:0]  msg_command;
   logic [15:0] msg_length;
   logic [6:0]  fill_count;
   logic        first_sent;
   logic [7:0]  seq_next;

   // Bytes of the item being framed; the newest is held back so the last can be marked.
   int               step_bytes;
   hrf_pkg::rsp_type pending_byte;
   logic             pending_valid;

   // Sender burst control and long receiver hold requests.
   int burst_left = 0;
   bit sender_gaps = 1'b1;
   int hold_requests = 0;
   int holds_done = 0;

   hid_report_framer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   always begin
      #(CLK_HALF) clock = 1'b1;
      #(CLK_HALF) clock = 1'b0;
   end

   // Append one byte to the current report, closing the report at its last byte.
   function automatic void emit_byte(input logic [7:0] value);
      hrf_pkg::rsp_type r;
      if (step_bytes >= MAX_STEP_BYTES)
         return;
      fill_count = fill_count + 7'd1;
      r.report_byte = value;
      r.last_of_report = 1'b0;
      r.last_of_step = 1'b0;
      if (fill_count >= 7'(hrf_pkg::REPORT_BYTES)) begin
         r.last_of_report = 1'b1;
         fill_count = '0;
      end
      if (pending_valid)
         report_stream_q.push_back(pending_byte);
      pending_byte = r;
      pending_valid = 1'b1;
      step_bytes++;
   endfunction

   // The channel id goes out low byte first.
   function automatic void emit_channel();
      emit_byte(msg_channel[7:0]);
      emit_byte(msg_channel[15:8]);
      emit_byte(msg_channel[23:16]);
      emit_byte(msg_channel[31:24]);
   endfunction

   function automatic void emit_first_header();
      emit_channel();
      emit_byte(msg_command);
      emit_byte(msg_length[15:8]);
      emit_byte(msg_length[7:0]);
   endfunction

   // Work out the report bytes that one accepted item causes.
   function automatic void frame_item(input hrf_pkg::req_type it);
      step_bytes = 0;
      pending_valid = 1'b0;
      case (it.action)
         hrf_pkg::ACT_START: begin
            msg_channel = it.channel_id;
            msg_command = it.command;
            msg_length = it.byte_count;
            fill_count = '0;
            first_sent = 1'b0;
            seq_next = '0;
         end
         hrf_pkg::ACT_DATA: begin
            if (fill_count == '0) begin
               if (!first_sent) begin
                  emit_first_header();
               end else begin
                  emit_channel();
                  emit_byte(seq_next);
                  seq_next = seq_next + 8'd1;
               end
            end
            emit_byte(it.data_byte);
            first_sent = 1'b1;
         end
         hrf_pkg::ACT_FLUSH: begin
            if (fill_count == '0 && !first_sent)
               emit_first_header();
            while (fill_count != '0 && step_bytes < MAX_STEP_BYTES)
               emit_byte(8'h00);
            fill_count = '0;
            first_sent = 1'b1;
         end
         default: ;
      endcase
      if (pending_valid) begin
         pending_byte.last_of_step = 1'b1;
         report_stream_q.push_back(pending_byte);
      end
   endfunction

   // An item with random content in every field and the given action.
   function automatic hrf_pkg::req_type random_item(input logic [1:0] action);
      hrf_pkg::req_type it;
      it.action = action;
      it.channel_id = $urandom;
      it.command = 8'($urandom);
      it.byte_count = 16'($urandom);
      it.data_byte = 8'($urandom);
      return it;
   endfunction

   // Offer one item and wait until it is accepted; gaps fall between bursts.
   task automatic send_item(input hrf_pkg::req_type it);
      int gap;
      if (burst_left == 0) begin
         gap = sender_gaps ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_item <= it;
      req_valid <= 1'b1;
      do
         @(posedge clock);
      while (!req_ready);
      frame_item(it);
      burst_left--;
      if (it.action != ACT_UNUSED)
         items_sent++;
   endtask

   task automatic send_data(input logic [7:0] value);
      hrf_pkg::req_type it;
      it = random_item(hrf_pkg::ACT_DATA);
      it.data_byte = value;
      send_item(it);
   endtask

   task automatic send_start(input logic [31:0] channel, input logic [7:0] command,
                             input logic [15:0] count);
      hrf_pkg::req_type it;
      it = random_item(hrf_pkg::ACT_START);
      it.channel_id = channel;
      it.command = command;
      it.byte_count = count;
      send_item(it);
   endtask

   // Data right after reset is framed with the cleared message registers.
   task automatic test_data_before_start();
      send_data(8'ha5);
      send_item(random_item(hrf_pkg::ACT_FLUSH));
   endtask

   task automatic test_field_extremes();
      send_start(32'hffff_ffff, 8'hff, 16'hffff);
      send_data(8'h00);
      send_data(8'hff);
      send_item(random_item(hrf_pkg::ACT_FLUSH));
      // A flush with nothing written gives a header-only report.
      send_start(32'h0000_0000, 8'h00, 16'h0000);
      send_item(random_item(hrf_pkg::ACT_FLUSH));
   endtask

   // A second flush sends nothing; later data opens a continuation report.
   task automatic test_flush_cases();
      send_item(random_item(hrf_pkg::ACT_FLUSH));
      send_data(8'h5a);
      send_item(random_item(hrf_pkg::ACT_FLUSH));
      send_item(random_item(hrf_pkg::ACT_FLUSH));
   endtask

   // A start drops an open report without padding it.
   task automatic test_start_drops_open();
      send_start(32'h1234_5678, 8'h83, 16'h0003);
      send_data(8'h01);
      send_data(8'h02);
      send_data(8'h03);
      send_start(32'h8765_4321, 8'h90, 16'h0001);
      send_data(8'h7e);
      send_item(random_item(hrf_pkg::ACT_FLUSH));
   endtask

   task automatic test_ignored_action();
      send_start(32'hcafe_0001, 8'h81, 16'h0002);
      send_item(random_item(ACT_UNUSED));
      send_data(8'h11);
      send_item(random_item(ACT_UNUSED));
      send_data(8'h22);
      send_item(random_item(hrf_pkg::ACT_FLUSH));
   endtask

   // Enough continuation reports for the sequence byte to wrap past 255.
   task automatic test_sequence_wrap();
      int n;
      send_start($urandom, 8'h83, 16'hbeef);
      for (n = 0; n < WRAP_REPORTS; n++) begin
         send_data(8'($urandom));
         send_item(random_item(hrf_pkg::ACT_FLUSH));
      end
   endtask

   // The receiver holds off while items keep coming, so the framer stalls its input.
   task automatic test_backpressure();
      int n;
      sender_gaps = 1'b0;
      hold_requests <= hold_requests + 1;
      send_start($urandom, 8'($urandom), 16'($urandom));
      for (n = 0; n < 70; n++)
         send_data(8'($urandom));
      send_item(random_item(hrf_pkg::ACT_FLUSH));
      sender_gaps = 1'b1;
   endtask

   // Mostly well-formed messages with random content, some noise and broken endings.
   task automatic test_random_messages();
      int first_count;
      int data_len;
      int n;
      int ending;
      first_count = items_sent;
      while (items_sent - first_count < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0) begin
            send_item(random_item(2'($urandom_range(0, 3))));
         end else begin
            send_item(random_item(hrf_pkg::ACT_START));
            if ($urandom_range(0, 5) == 0)
               data_len = $urandom_range(50, 130);
            else
               data_len = $urandom_range(0, 12);
            for (n = 0; n < data_len; n++) begin
               if ($urandom_range(0, 19) == 0)
                  send_item(random_item(ACT_UNUSED));
               send_item(random_item(hrf_pkg::ACT_DATA));
            end
            ending = $urandom_range(0, 9);
            if (ending < 9)
               send_item(random_item(hrf_pkg::ACT_FLUSH));
            if (ending == 8)
               send_item(random_item(hrf_pkg::ACT_FLUSH));
         end
      end
   endtask

   // Receiver: switches among stall patterns and serves long hold requests.
   initial begin : receiver
      rx_mode_type mode;
      int mode_left;
      int tick;
      mode = RX_ALWAYS;
      mode_left = 0;
      tick = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            holds_done++;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         if (mode_left == 0) begin
            mode = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(50, 300);
         end
         mode_left--;
         tick++;
         case (mode)
            RX_ALWAYS: rsp_ready <= 1'b1;
            RX_COIN:   rsp_ready <= ($urandom_range(0, 1) == 1);
            RX_THIRD:  rsp_ready <= (tick % 3 != 0);
            default:   rsp_ready <= (tick % 8 < 5);
         endcase
      end
   end

   function automatic void check_field(input string field, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         fail_count++;
      end
   endfunction

   // Compare every accepted result with the oldest predicted byte.
   always @(posedge clock) begin : check_results
      hrf_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (report_stream_q.size() == 0) begin
            $error("report_byte: no byte predicted, got %0h", rsp_item.report_byte);
            fail_count++;
         end else begin
            want = report_stream_q.pop_front();
            check_field("report_byte", want.report_byte, rsp_item.report_byte);
            check_field("last_of_report", want.last_of_report, rsp_item.last_of_report);
            check_field("last_of_step", want.last_of_step, rsp_item.last_of_step);
         end
      end
   end

   initial begin
      msg_channel = '0;
      msg_command = '0;
      msg_length = '0;
      fill_count = '0;
      first_sent = 1'b0;
      seq_next = '0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_item <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_data_before_start();
      test_field_extremes();
      test_flush_cases();
      test_start_drops_open();
      test_ignored_action();
      test_sequence_wrap();
      test_backpressure();
      test_random_messages();

      // Let the framer finish every predicted byte.
      req_valid <= 1'b0;
      while (report_stream_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && report_stream_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(2 * CLK_HALF * TIMEOUT_CYCLES);
      $error("timeout with %0d report bytes outstanding", report_stream_q.size());
      $display("Some tests failed");
      $finish;
   end

endmodule
